[hw/rtl/hhbp_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP header block parser package
// Shared types and codes for the parser: phase codes, byte roles, the
// parser state record and the per-byte result record.
// ---------------------------------------------------------------------------
package hhbp_pkg;

   // Parser phases
   localparam logic [2:0] PH_LEAD   = 3'd0;
   localparam logic [2:0] PH_NAME   = 3'd1;
   localparam logic [2:0] PH_SPACES = 3'd2;
   localparam logic [2:0] PH_VALUE  = 3'd3;
   localparam logic [2:0] PH_EAT    = 3'd4;
   localparam logic [2:0] PH_BODY   = 3'd5;
   localparam logic [2:0] PH_BLANK  = 3'd6;

   // Byte roles
   localparam logic [1:0] ROLE_SKIP  = 2'd0;
   localparam logic [1:0] ROLE_NAME  = 2'd1;
   localparam logic [1:0] ROLE_VALUE = 2'd2;
   localparam logic [1:0] ROLE_BODY  = 2'd3;

   // UTF-8 first continuation byte bound
   localparam logic [1:0] LIM_NONE = 2'd0;
   localparam logic [1:0] LIM_LOW  = 2'd1;
   localparam logic [1:0] LIM_HIGH = 2'd2;

   // Characters of interest
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef struct packed {
      logic [1:0] remaining;
      logic [1:0] first_limit;
   } utf8_state_type;

   typedef struct packed {
      logic [2:0]     phase;
      logic           name_seen;
      utf8_state_type utf8;
   } parse_state_type;

   typedef struct packed {
      logic [1:0] role;
      logic       field_done;
      logic       headers_done;
      logic       line_failed;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:     PH_LEAD,
      name_seen: 1'b0,
      utf8:      '{remaining: 2'd0, first_limit: LIM_NONE}
   };

endpackage

[hw/rtl/http_header_block_parser.sv]
`timescale 1ns / 1ps
// A request passes through the input register and the output register to the ports.
// Throughput: one byte per cycle unless rsp_stall holds the output register.
// The input register can take a request while a result waits in the output register.
// Reset (synchronous, active high) empties both registers and returns the parser
// to the leading whitespace skip.
// ---------------------------------------------------------------------------
// HTTP header block parser
// Tags each byte of a raw header buffer as skipped, name, value or body,
// with field, header-section and failure flags.
// ---------------------------------------------------------------------------
module http_header_block_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_in,
   input  logic       req_end_of_buffer,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_role,
   output logic       rsp_field_done,
   output logic       rsp_headers_done,
   output logic       rsp_line_failed,
   output logic       rsp_last_out
);
   import hhbp_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_eob_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   parse_result_type out_result_ff;
   parse_state_type  state_ff;
   parse_state_type  state_in;
   parse_result_type result_in;
   logic             out_free;
   logic             advance;

   // Handshake: the input register moves on whenever the output register is
   // empty or being emptied.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_in;
         in_eob_ff  <= req_end_of_buffer;
      end
   end

   hhbp_step u_step (
      .byte_in       (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .state_cur     (state_ff),
      .state_nxt     (state_in),
      .result        (result_in)
   );

   // Parser state, updated as each request passes to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
      if (advance) begin
         out_byte_ff   <= in_byte_ff;
         out_last_ff   <= in_eob_ff;
         out_result_ff <= result_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_out     = out_byte_ff;
   assign rsp_role         = out_result_ff.role;
   assign rsp_field_done   = out_result_ff.field_done;
   assign rsp_headers_done = out_result_ff.headers_done;
   assign rsp_line_failed  = out_result_ff.line_failed;
   assign rsp_last_out     = out_last_ff;

endmodule

[hw/rtl/hhbp_utf8.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP header block parser: UTF-8 checker
// Decides whether one value byte is acceptable UTF-8 at this point and gives
// the decoder state that follows it.
// ---------------------------------------------------------------------------
module hhbp_utf8 (
   input  logic [7:0]              byte_in,
   input  hhbp_pkg::utf8_state_type state_cur,
   output logic                    accept,
   output hhbp_pkg::utf8_state_type state_nxt
);
   import hhbp_pkg::*;

   logic [7:0] lo_bound;
   logic [7:0] hi_bound;

   // Bounds on a continuation byte; the first one after E0, ED, F0 or F4 is
   // narrowed to rule out overlongs, surrogates and code points past U+10FFFF.
   always_comb begin
      lo_bound = 8'h80;
      hi_bound = 8'hBF;
      if (state_cur.first_limit == LIM_LOW) begin
         lo_bound = (state_cur.remaining == 2'd2) ? 8'hA0 : 8'h90;
      end
      if (state_cur.first_limit == LIM_HIGH) begin
         hi_bound = (state_cur.remaining == 2'd2) ? 8'h9F : 8'h8F;
      end
   end

   // Lead byte classification or continuation check.
   always_comb begin
      accept    = 1'b0;
      state_nxt = '{remaining: 2'd0, first_limit: LIM_NONE};
      if (state_cur.remaining == 2'd0) begin
         case (byte_in) inside
            [8'h00:8'h7F]: begin
               accept = 1'b1;
            end
            [8'hC2:8'hDF]: begin
               accept              = 1'b1;
               state_nxt.remaining = 2'd1;
            end
            8'hE0: begin
               accept    = 1'b1;
               state_nxt = '{remaining: 2'd2, first_limit: LIM_LOW};
            end
            8'hED: begin
               accept    = 1'b1;
               state_nxt = '{remaining: 2'd2, first_limit: LIM_HIGH};
            end
            [8'hE1:8'hEC], [8'hEE:8'hEF]: begin
               accept              = 1'b1;
               state_nxt.remaining = 2'd2;
            end
            8'hF0: begin
               accept    = 1'b1;
               state_nxt = '{remaining: 2'd3, first_limit: LIM_LOW};
            end
            8'hF4: begin
               accept    = 1'b1;
               state_nxt = '{remaining: 2'd3, first_limit: LIM_HIGH};
            end
            [8'hF1:8'hF3]: begin
               accept              = 1'b1;
               state_nxt.remaining = 2'd3;
            end
            default: begin
               accept = 1'b0;
            end
         endcase
      end else begin
         if ((byte_in >= lo_bound) && (byte_in <= hi_bound)) begin
            accept              = 1'b1;
            state_nxt.remaining = state_cur.remaining - 2'd1;
         end
      end
   end

endmodule

[hw/rtl/hhbp_step.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP header block parser: byte step
// Works out the role of one byte and the parser state after it, from the
// registered byte and the current parser state.
// ---------------------------------------------------------------------------
module hhbp_step (
   input  logic [7:0]                byte_in,
   input  logic                      end_of_buffer,
   input  hhbp_pkg::parse_state_type  state_cur,
   output hhbp_pkg::parse_state_type  state_nxt,
   output hhbp_pkg::parse_result_type result
);
   import hhbp_pkg::*;

   // Token characters of a header field name.
   function automatic logic is_token_char(input logic [7:0] c);
      logic ok;
      case (c) inside
         [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
         8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   logic           utf8_ok;
   utf8_state_type utf8_nxt;

   hhbp_utf8 u_utf8 (
      .byte_in   (byte_in),
      .state_cur (state_cur.utf8),
      .accept    (utf8_ok),
      .state_nxt (utf8_nxt)
   );

   parse_state_type st;
   logic [1:0]      role;
   logic            fd;
   logic            hd;
   logic            fail;
   logic            line_end;

   always_comb begin
      st       = state_cur;
      role     = ROLE_SKIP;
      fd       = 1'b0;
      hd       = 1'b0;
      fail     = 1'b0;
      line_end = 1'b0;

      // Leaving the leading skip or the spaces after a colon.
      if (st.phase == PH_LEAD) begin
         if ((byte_in != CH_SPACE) && (byte_in != CH_LF) && (byte_in != CH_CR)) begin
            st.phase     = PH_NAME;
            st.name_seen = 1'b0;
         end
      end else if ((st.phase == PH_SPACES) && (byte_in != CH_SPACE)) begin
         st.phase = PH_VALUE;
         st.utf8  = '{remaining: 2'd0, first_limit: LIM_NONE};
      end

      // Main phase decode.
      case (st.phase)
         PH_LEAD, PH_SPACES: begin
            role = ROLE_SKIP;
         end
         PH_NAME: begin
            if (byte_in == CH_COLON) begin
               st.phase = PH_SPACES;
            end else if (byte_in == CH_CR) begin
               if (st.name_seen) begin
                  fail = 1'b1;
               end else begin
                  st.phase = PH_BLANK;
               end
            end else if (is_token_char(byte_in)) begin
               role         = ROLE_NAME;
               st.name_seen = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         PH_VALUE: begin
            if (byte_in == CH_CR) begin
               if (st.utf8.remaining != 2'd0) begin
                  fail = 1'b1;
               end else begin
                  st.phase = PH_EAT;
               end
            end else if (byte_in == CH_LF) begin
               if (st.utf8.remaining != 2'd0) begin
                  fail = 1'b1;
               end else begin
                  line_end = 1'b1;
               end
            end else if (utf8_ok) begin
               role    = ROLE_VALUE;
               st.utf8 = utf8_nxt;
            end else begin
               fail = 1'b1;
            end
         end
         PH_EAT: begin
            line_end = 1'b1;
         end
         PH_BLANK: begin
            if (byte_in == CH_LF) begin
               hd       = 1'b1;
               st.phase = PH_BODY;
            end else begin
               fail = 1'b1;
            end
         end
         default: begin
            role = ROLE_BODY;
         end
      endcase

      // End of a header line: a field, or the end of the header section
      // when the name was empty.
      if (line_end) begin
         st.utf8 = '{remaining: 2'd0, first_limit: LIM_NONE};
         if (st.name_seen) begin
            fd           = 1'b1;
            st.phase     = PH_NAME;
            st.name_seen = 1'b0;
         end else begin
            hd       = 1'b1;
            st.phase = PH_BODY;
         end
      end

      // The buffer ending in mid-line fails that line.
      if (!fail && end_of_buffer && !line_end && !hd &&
          (st.phase != PH_LEAD) && (st.phase != PH_BODY)) begin
         fail = 1'b1;
      end

      if (fail) begin
         role     = ROLE_BODY;
         st.phase = PH_BODY;
         st.utf8  = '{remaining: 2'd0, first_limit: LIM_NONE};
      end

      // Each buffer's last byte returns the parser to its reset state.
      if (end_of_buffer) begin
         st = STATE_RESET;
      end
   end

   assign state_nxt = st;
   assign result    = '{role: role, field_done: fd, headers_done: hd, line_failed: fail};

endmodule

[hw/rtl/hhbp_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP header block parser checker
// Port-level assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module hhbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_byte_out,
   input logic [1:0] rsp_role,
   input logic       rsp_field_done,
   input logic       rsp_headers_done,
   input logic       rsp_line_failed
);
   import hhbp_pkg::*;

   // A stalled result holds its byte and role.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_out) && $stable(rsp_role))
      else $error("stalled result changed");

   // A failed line turns the failing byte into body and never ends the headers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_failed |-> rsp_role == ROLE_BODY && !rsp_headers_done
         && !rsp_field_done)
      else $error("failed line has wrong flags");

   // A line end is a separator byte and ends either a field or the headers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_field_done || rsp_headers_done) |->
         rsp_role == ROLE_SKIP && !(rsp_field_done && rsp_headers_done))
      else $error("line end flags inconsistent");

   // After the header section ends, the next result is never a value byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_headers_done ##1 rsp_valid |->
         rsp_role == ROLE_BODY || rsp_role == ROLE_SKIP || rsp_role == ROLE_NAME)
      else $error("byte after header end has a value role");

endmodule

bind http_header_block_parser hhbp_checker u_hhbp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_byte_out     (rsp_byte_out),
   .rsp_role         (rsp_role),
   .rsp_field_done   (rsp_field_done),
   .rsp_headers_done (rsp_headers_done),
   .rsp_line_failed  (rsp_line_failed)
);

[test/tb_http_header_block_parser.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP header block parser testbench
// Streams raw header buffers through the parser one request at a time and
// checks every tagged byte against a byte-by-byte parser model or a pinned row.
// A short table of hand-picked requests comes first, then random buffers
// that are mostly well-formed header sections with random names and UTF-8
// values, some of them corrupted, cut short or replaced by plain noise.
// Both sides of the block idle and stall at random.
// ---------------------------------------------------------------------------
module tb_http_header_block_parser;
   import hhbp_pkg::*;

   localparam int RANDOM_REQUESTS = 1950;
   localparam int QUIET_LIMIT     = 1000;
   localparam int MAX_GAP         = 13;

   // One tagged byte as it leaves the parser.
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] role;
      logic       field_done;
      logic       headers_done;
      logic       failed;
      logic       last;
   } byte_tag_type;

   // One request; pinned rows carry a tag written out by hand.
   typedef struct packed {
      logic [7:0] data;
      logic       eob;
      logic       pinned;
      logic [1:0] role;
      logic       field_done;
      logic       headers_done;
      logic       failed;
   } request_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte_in;
   logic       req_end_of_buffer;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_byte_out;
   logic [1:0] rsp_role;
   logic       rsp_field_done;
   logic       rsp_headers_done;
   logic       rsp_line_failed;
   logic       rsp_last_out;

   request_type  request_list[$];
   byte_tag_type pending_tags[$];
   int           accepted_count;
   int           error_count;
   int           quiet_cycles;

   // Parser model state.
   logic [2:0] parser_phase;
   logic       in_name;
   logic [1:0] utf8_left;
   logic [1:0] utf8_bound;

   // Hand-picked requests: leading skip, a field with a three-byte value
   // ended by CR and an eaten byte, a blank line, a bad first byte, an empty
   // name, LF inside a name, bad UTF-8 and a buffer ending mid-name.
   request_type directed_rows [0:25] = '{
      '{8'h20, 1'b0, 1'b1, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_CR, 1'b0, 1'b1, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{8'h41, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_COLON, 1'b0, 1'b0, ROLE_SKIP, 1'b0, 1'b0, 1'b0},
      '{8'h20, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{8'hE0, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{8'hA0, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_CR, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b0, 1'b1, ROLE_SKIP,  1'b1, 1'b0, 1'b0},
      '{CH_CR, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_LF, 1'b1, 1'b1, ROLE_SKIP,  1'b0, 1'b1, 1'b0},
      '{8'h00, 1'b0, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b0},
      '{CH_COLON, 1'b0, 1'b0, ROLE_SKIP, 1'b0, 1'b0, 1'b0},
      '{8'h78, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_LF, 1'b0, 1'b1, ROLE_SKIP,  1'b0, 1'b1, 1'b0},
      '{8'h79, 1'b1, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b0},
      '{8'h6B, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_LF, 1'b0, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b1},
      '{8'h7A, 1'b1, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b0},
      '{8'h61, 1'b0, 1'b0, ROLE_SKIP,  1'b0, 1'b0, 1'b0},
      '{CH_COLON, 1'b0, 1'b0, ROLE_SKIP, 1'b0, 1'b0, 1'b0},
      '{8'hC0, 1'b0, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b1},
      '{8'h41, 1'b1, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b0},
      '{8'h62, 1'b1, 1'b1, ROLE_BODY,  1'b0, 1'b0, 1'b1}
   };

   http_header_block_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte_in       (req_byte_in),
      .req_end_of_buffer (req_end_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_role          (rsp_role),
      .rsp_field_done    (rsp_field_done),
      .rsp_headers_done  (rsp_headers_done),
      .rsp_line_failed   (rsp_line_failed),
      .rsp_last_out      (rsp_last_out)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // RFC 7230 token characters.
   function automatic logic is_token(input logic [7:0] c);
      case (c)
         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
         8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
         default: return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                         (c >= 8'h61 && c <= 8'h7A);
      endcase
   endfunction

   function automatic void reset_parser_model();
      parser_phase = PH_LEAD;
      in_name      = 1'b0;
      utf8_left    = 2'd0;
      utf8_bound   = LIM_NONE;
   endfunction

   // Tags one byte and advances the parser model.
   function automatic byte_tag_type classify_byte(input logic [7:0] b, input logic eob);
      byte_tag_type tag;
      logic         line_end;
      logic         fail;
      logic         ok;
      logic [7:0]   lo;
      logic [7:0]   hi;
      tag      = '0;
      tag.data = b;
      tag.last = eob;
      line_end = 1'b0;
      fail     = 1'b0;

      // Leaving the leading skip or the spaces after the colon.
      if (parser_phase == PH_LEAD) begin
         if (b != CH_SPACE && b != CH_LF && b != CH_CR) begin
            parser_phase = PH_NAME;
            in_name      = 1'b0;
         end
      end else if (parser_phase == PH_SPACES && b != CH_SPACE) begin
         parser_phase = PH_VALUE;
         utf8_left    = 2'd0;
         utf8_bound   = LIM_NONE;
      end

      case (parser_phase)
         PH_NAME: begin
            if (b == CH_COLON) begin
               parser_phase = PH_SPACES;
            end else if (b == CH_CR) begin
               if (in_name) fail = 1'b1;
               else parser_phase = PH_BLANK;
            end else if (is_token(b)) begin
               tag.role = ROLE_NAME;
               in_name  = 1'b1;
            end else begin
               fail = 1'b1;
            end
         end
         PH_VALUE: begin
            if (b == CH_CR || b == CH_LF) begin
               if (utf8_left != 2'd0) fail = 1'b1;
               else if (b == CH_CR) parser_phase = PH_EAT;
               else line_end = 1'b1;
            end else begin
               // UTF-8 check: no overlongs, no surrogates, nothing past U+10FFFF.
               ok = 1'b1;
               if (utf8_left == 2'd0) begin
                  utf8_bound = LIM_NONE;
                  if (b >= 8'h80) begin
                     if (b >= 8'hC2 && b <= 8'hDF) begin
                        utf8_left = 2'd1;
                     end else if (b == 8'hE0) begin
                        utf8_left  = 2'd2;
                        utf8_bound = LIM_LOW;
                     end else if (b == 8'hED) begin
                        utf8_left  = 2'd2;
                        utf8_bound = LIM_HIGH;
                     end else if (b >= 8'hE1 && b <= 8'hEF) begin
                        utf8_left = 2'd2;
                     end else if (b == 8'hF0) begin
                        utf8_left  = 2'd3;
                        utf8_bound = LIM_LOW;
                     end else if (b == 8'hF4) begin
                        utf8_left  = 2'd3;
                        utf8_bound = LIM_HIGH;
                     end else if (b >= 8'hF1 && b <= 8'hF3) begin
                        utf8_left = 2'd3;
                     end else begin
                        ok = 1'b0;
                     end
                  end
               end else begin
                  lo = 8'h80;
                  hi = 8'hBF;
                  if (utf8_bound == LIM_LOW) lo = (utf8_left == 2'd2) ? 8'hA0 : 8'h90;
                  if (utf8_bound == LIM_HIGH) hi = (utf8_left == 2'd2) ? 8'h9F : 8'h8F;
                  if (b < lo || b > hi) begin
                     ok = 1'b0;
                  end else begin
                     utf8_left  = utf8_left - 2'd1;
                     utf8_bound = LIM_NONE;
                  end
               end
               if (ok) tag.role = ROLE_VALUE;
               else fail = 1'b1;
            end
         end
         PH_EAT: begin
            line_end = 1'b1;
         end
         PH_BLANK: begin
            if (b == CH_LF) begin
               tag.headers_done = 1'b1;
               parser_phase     = PH_BODY;
            end else begin
               fail = 1'b1;
            end
         end
         PH_BODY: begin
            tag.role = ROLE_BODY;
         end
         default: begin
         end
      endcase

      // A finished line either completes a field or, with an empty name,
      // closes the header section.
      if (line_end) begin
         utf8_left  = 2'd0;
         utf8_bound = LIM_NONE;
         if (in_name) begin
            tag.field_done = 1'b1;
            parser_phase   = PH_NAME;
            in_name        = 1'b0;
         end else begin
            tag.headers_done = 1'b1;
            parser_phase     = PH_BODY;
         end
      end

      // The buffer ending in mid-line fails that line.
      if (!fail && eob && !line_end && !tag.headers_done &&
          parser_phase != PH_LEAD && parser_phase != PH_BODY)
         fail = 1'b1;

      if (fail) begin
         tag.role     = ROLE_BODY;
         parser_phase = PH_BODY;
         utf8_left    = 2'd0;
         utf8_bound   = LIM_NONE;
      end
      tag.failed = fail;

      if (eob) reset_parser_model();
      return tag;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      request_type req;
      req      = '0;
      req.data = b;
      request_list.push_back(req);
   endfunction

   function automatic logic [7:0] token_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(8'h21, 8'h7E)); while (!is_token(c));
      return c;
   endfunction

   // Appends one valid UTF-8 character that holds neither CR nor LF.
   function automatic void add_utf8_char();
      logic [7:0] lead;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            do lead = 8'($urandom_range(0, 127)); while (lead == CH_CR || lead == CH_LF);
            add_byte(lead);
         end
         4: begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         5: begin
            add_byte(8'hE0);
            add_byte(8'($urandom_range(8'hA0, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         6: begin
            add_byte(8'hED);
            add_byte(8'($urandom_range(8'h80, 8'h9F)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         7: begin
            lead = 8'($urandom_range(8'hE1, 8'hEF));
            add_byte(lead);
            add_byte(8'(lead == 8'hED ? $urandom_range(8'h80, 8'h9F)
                                      : $urandom_range(8'h80, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         8: begin
            add_byte(8'hF0);
            add_byte(8'($urandom_range(8'h90, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
         default: begin
            lead = 8'($urandom_range(8'hF1, 8'hF4));
            add_byte(lead);
            add_byte(8'(lead == 8'hF4 ? $urandom_range(8'h80, 8'h8F)
                                      : $urandom_range(8'h80, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
            add_byte(8'($urandom_range(8'h80, 8'hBF)));
         end
      endcase
   endfunction

   // Appends one buffer: mostly a header section, sometimes damaged,
   // sometimes plain noise.
   function automatic void add_buffer();
      int first;
      int k;
      first = request_list.size();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 2)) begin
            k = $urandom_range(0, 2);
            add_byte(k == 0 ? CH_SPACE : (k == 1 ? CH_CR : CH_LF));
         end
         repeat ($urandom_range(1, 4)) begin
            repeat ($urandom_range(1, 6)) add_byte(token_byte());
            add_byte(CH_COLON);
            repeat ($urandom_range(0, 2)) add_byte(CH_SPACE);
            repeat ($urandom_range(0, 5)) add_utf8_char();
            if ($urandom_range(0, 1) == 1) begin
               add_byte(CH_CR);
               add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) : CH_LF);
            end else begin
               add_byte(CH_LF);
            end
         end
         // Close with a blank line, an empty-name line, the last field, or cut
         // the buffer off in the middle of a name.
         case ($urandom_range(0, 3))
            0: begin
               add_byte(CH_CR);
               add_byte(CH_LF);
               repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            1: begin
               add_byte(CH_COLON);
               repeat ($urandom_range(0, 2)) add_utf8_char();
               add_byte(CH_LF);
               repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            end
            2: begin
            end
            default: begin
               repeat ($urandom_range(1, 3)) add_byte(token_byte());
            end
         endcase
         if ($urandom_range(0, 4) == 0)
            request_list[first + $urandom_range(0, request_list.size() - first - 1)].data =
               8'($urandom_range(0, 255));
      end
      request_list[request_list.size() - 1].eob = 1'b1;
   endfunction

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   // Scoreboard: tag each accepted request, check each accepted result
   // against the oldest tag, and watch for a hung interface.
   always @(posedge clock) begin
      byte_tag_type want;
      request_type  req;
      if (reset) begin
         reset_parser_model();
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_tags.size() == 0) begin
               $display("%0t ns: unexpected result, byte_out 0x%0h", $time, rsp_byte_out);
               error_count++;
            end else begin
               want = pending_tags.pop_front();
               if (rsp_byte_out !== want.data)
                  report_field("byte_out", want.data, rsp_byte_out);
               if (rsp_role !== want.role)
                  report_field("role", 8'(want.role), 8'(rsp_role));
               if (rsp_field_done !== want.field_done)
                  report_field("field_done", 8'(want.field_done), 8'(rsp_field_done));
               if (rsp_headers_done !== want.headers_done)
                  report_field("headers_done", 8'(want.headers_done),
                               8'(rsp_headers_done));
               if (rsp_line_failed !== want.failed)
                  report_field("line_failed", 8'(want.failed), 8'(rsp_line_failed));
               if (rsp_last_out !== want.last)
                  report_field("last_out", 8'(want.last), 8'(rsp_last_out));
            end
         end

         if (req_valid && !req_stall) begin
            req  = request_list[accepted_count];
            want = classify_byte(req_byte_in, req_end_of_buffer);
            if (req.pinned) begin
               want.role         = req.role;
               want.field_done   = req.field_done;
               want.headers_done = req.headers_done;
               want.failed       = req.failed;
            end
            pending_tags.push_back(want);
            accepted_count++;
         end

         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Result side: stall for a random number of cycles before each result,
   // with occasional runs of no stalling at all.
   initial begin
      logic stall_idle;
      int   gap;
      rsp_stall  = 1'b0;
      stall_idle = 1'b1;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 49) == 0) stall_idle = !stall_idle;
         gap = stall_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Request side: reset, build the stimulus, send it, then drain.
   initial begin
      logic send_idle;
      int   gap;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_byte_in       = 8'h00;
      req_end_of_buffer = 1'b0;
      accepted_count    = 0;
      error_count       = 0;
      quiet_cycles      = 0;
      send_idle         = 1'b1;

      foreach (directed_rows[i]) request_list.push_back(directed_rows[i]);
      while (request_list.size() < $size(directed_rows) + RANDOM_REQUESTS) add_buffer();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (request_list[i]) begin
         if ($urandom_range(0, 49) == 0) send_idle = !send_idle;
         gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid         <= 1'b1;
         req_byte_in       <= request_list[i].data;
         req_end_of_buffer <= request_list[i].eob;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      // Drain the remaining results, then give the pipeline time to show
      // anything it should not.
      while (pending_tags.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/hhbp_pkg.sv
hw/rtl/hhbp_utf8.sv
hw/rtl/hhbp_step.sv
hw/rtl/http_header_block_parser.sv
hw/rtl/hhbp_checker.sv
test/tb_http_header_block_parser.sv
